>>> sv/rgb_time_slice_color_mixer_core_macros.svh
// Assertion macros for the RGB time-slice colour mixer core
`ifndef RGB_TIME_SLICE_COLOR_MIXER_CORE_MACROS_SVH
`define RGB_TIME_SLICE_COLOR_MIXER_CORE_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset
`define RGBTSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rgbtsm: same-cycle check failed");

// Next-cycle implication, checked on aclk outside reset
`define RGBTSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rgbtsm: next-cycle check failed");

`endif

>>> sv/rgbtsm_pkg.sv
// Shared types, constants and helpers for the RGB time-slice colour mixer
package rgbtsm_pkg;

    localparam int COUNT_W = 13;
    localparam int SHARE_W = 12;
    localparam int LEN_W   = 18;
    localparam int PROD_W  = COUNT_W + SHARE_W;
    localparam int TPU_W   = 6;
    localparam int STEP_W  = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    localparam logic [STEP_W-1:0]  STEP_RESET = 8'd1;
    localparam logic [SHARE_W-1:0] FS_RESET   = 12'd1000;
    localparam logic [TPU_W-1:0]   TPU_RESET  = 6'd11;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_STEP = 2'd0;
    localparam logic [1:0] REG_FS   = 2'd1;
    localparam logic [1:0] REG_TPU  = 2'd2;

    // Channel / slot codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Input kinds
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Key port codes
    localparam logic [7:0] KC_RED_INC   = 8'h10;
    localparam logic [7:0] KC_RED_DEC   = 8'h04;
    localparam logic [7:0] KC_GREEN_INC = 8'h20;
    localparam logic [7:0] KC_GREEN_DEC = 8'h02;
    localparam logic [7:0] KC_BLUE_INC  = 8'h40;
    localparam logic [7:0] KC_BLUE_DEC  = 8'h08;

    typedef struct packed {
        logic [STEP_W-1:0]  step_size;
        logic [SHARE_W-1:0] full_scale;
        logic [TPU_W-1:0]   ticks_per_unit;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [SHARE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [SHARE_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] ch;
        logic       up;
    } key_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_DWAIT,
        ST_FIX,
        ST_LEN,
        ST_DONE
    } state_t;

    function automatic key_t key_decode(input logic [7:0] code);
        key_t k;
        k = '{hit: 1'b1, ch: CH_RED, up: 1'b0};
        case (code)
            KC_RED_INC:   k = '{hit: 1'b1, ch: CH_RED,   up: 1'b1};
            KC_RED_DEC:   k = '{hit: 1'b1, ch: CH_RED,   up: 1'b0};
            KC_GREEN_INC: k = '{hit: 1'b1, ch: CH_GREEN, up: 1'b1};
            KC_GREEN_DEC: k = '{hit: 1'b1, ch: CH_GREEN, up: 1'b0};
            KC_BLUE_INC:  k = '{hit: 1'b1, ch: CH_BLUE,  up: 1'b1};
            KC_BLUE_DEC:  k = '{hit: 1'b1, ch: CH_BLUE,  up: 1'b0};
            default:      k = '{hit: 1'b0, ch: CH_RED,   up: 1'b0};
        endcase
        return k;
    endfunction

    // Next slot in red -> green -> blue -> red order
    function automatic logic [1:0] next_ch(input logic [1:0] ch);
        logic [1:0] n;
        case (ch)
            CH_RED:   n = CH_GREEN;
            CH_GREEN: n = CH_BLUE;
            default:  n = CH_RED;
        endcase
        return n;
    endfunction

endpackage

>>> sv/rgbtsm_regs.sv
// APB configuration registers of the colour mixer
module rgbtsm_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output rgbtsm_pkg::cfg_t  cfg
);

    rgbtsm_pkg::cfg_t cfg_reg, cfg_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                rgbtsm_pkg::REG_STEP: cfg_next.step_size      = pwdata[7:0];
                rgbtsm_pkg::REG_FS:   cfg_next.full_scale     = pwdata[11:0];
                rgbtsm_pkg::REG_TPU:  cfg_next.ticks_per_unit = pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rgbtsm_pkg::REG_STEP: prdata = {24'd0, cfg_reg.step_size};
            rgbtsm_pkg::REG_FS:   prdata = {20'd0, cfg_reg.full_scale};
            rgbtsm_pkg::REG_TPU:  prdata = {26'd0, cfg_reg.ticks_per_unit};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_size      <= rgbtsm_pkg::STEP_RESET;
            cfg_reg.full_scale     <= rgbtsm_pkg::FS_RESET;
            cfg_reg.ticks_per_unit <= rgbtsm_pkg::TPU_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/rgbtsm_div.sv
// Iterative restoring divider, one quotient bit per cycle
module rgbtsm_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rgbtsm_pkg::div_req_t req,
    output rgbtsm_pkg::div_rsp_t rsp
);

    localparam int QW = rgbtsm_pkg::SHARE_W;
    localparam logic [3:0] ITER = 4'(QW);

    logic [QW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [QW-1:0] dvs_reg, dvs_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [QW:0]   trial;
    logic          ge;

    // Quotient is known to fit QW bits, so the high part starts below the divisor
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.dividend[rgbtsm_pkg::PROD_W-2:QW];
            quo_next  = req.dividend[QW-1:0];
            dvs_next  = req.divisor;
            cnt_next  = ITER;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? QW'(trial - {1'b0, dvs_reg}) : trial[QW-1:0];
            quo_next = {quo_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> sv/rgb_time_slice_color_mixer_core.sv
// Top level of the RGB time-slice colour mixer: sequencer, state and stream ports
//
// Time-division PWM for one RGB LED. Each input transfer is either a timer
// tick (s_tuser = 1) or a key press (s_tuser = 0, key code in s_tdata), and
// every input transfer yields exactly one result transfer showing the LED
// drive, current slot and running flag after that event. A tick, or a key
// code that is not one of the six colour keys, is answered straight from the
// idle state, so ticks can stream back to back as long as the result side
// keeps up. A recognised key runs through the sequencer from its transfer to
// its result (the divisions are skipped when the new count sum is zero or
// above full_scale), and s_tready stays low meanwhile: the count sum is
// checked, then each of the three shares count*full_scale/sum goes through
// one shared multiplier and a 12-step restoring divider, the leftover units
// are handed out, and the three slot lengths share*ticks_per_unit+1 are
// formed through the same multiplier. Rotation then restarts at the red slot.
// Configuration is written over APB (step_size at 0x0, full_scale at 0x4,
// ticks_per_unit at 0x8) and takes effect at the next recognised key.
`include "rgb_time_slice_color_mixer_core_macros.svh"

module rgb_time_slice_color_mixer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_code
    input  logic        s_tuser,   // [0] kind (0 key press, 1 tick)
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] led_drive, [4:3] slot, [5] running, [7:6] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = rgbtsm_pkg::COUNT_W;
    localparam int SW = rgbtsm_pkg::SHARE_W;
    localparam int LW = rgbtsm_pkg::LEN_W;
    localparam int PW = rgbtsm_pkg::PROD_W;

    rgbtsm_pkg::cfg_t     cfg;
    rgbtsm_pkg::div_req_t div_req;
    rgbtsm_pkg::div_rsp_t div_rsp;
    rgbtsm_pkg::key_t     key;

    rgbtsm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rgbtsm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Colour state
    logic [CW-1:0] count_reg [3];
    logic [CW-1:0] count_next [3];
    logic [LW-1:0] len_reg [3];
    logic [LW-1:0] len_next [3];
    logic [SW-1:0] share_reg [3];
    logic [SW-1:0] share_next [3];
    logic [1:0]    slot_reg, slot_next;
    logic [LW-1:0] ticks_reg, ticks_next;
    logic          active_reg, active_next;

    // Sequencer
    rgbtsm_pkg::state_t state_reg, state_next;
    logic [1:0]    idx_reg, idx_next;
    logic [1:0]    pressed_reg, pressed_next;
    logic [SW-1:0] sum_reg, sum_next;

    // Result register
    logic          m_valid_reg, m_valid_next;
    logic [5:0]    m_data_reg, m_data_next;

    // Shared datapath
    logic [CW-1:0]   mul_a;
    logic [SW-1:0]   mul_b;
    logic [PW-1:0]   mul_p;
    logic [CW+1:0]   sum_all;
    logic [CW:0]     up_val;
    logic [SW+1:0]   used;
    logic [1:0]      target;
    logic            in_xfer;
    logic            load_out;
    logic            key_start;
    logic [2:0]      led;

    assign key     = rgbtsm_pkg::key_decode(s_tdata);
    assign in_xfer = s_tvalid && s_tready;
    assign key_start = in_xfer && (s_tuser == rgbtsm_pkg::KIND_KEY) && key.hit;

    // Take a new transfer only when idle and the result slot is free this cycle
    assign s_tready = (state_reg == rgbtsm_pkg::ST_IDLE) && (!m_valid_reg || m_tready);

    // One multiplier serves both the share numerators and the slot lengths
    always_comb begin
        if (state_reg == rgbtsm_pkg::ST_LEN) begin
            mul_a = {1'b0, share_reg[idx_reg]};
            mul_b = {6'd0, cfg.ticks_per_unit};
        end else begin
            mul_a = count_reg[idx_reg];
            mul_b = cfg.full_scale;
        end
    end
    assign mul_p = {{SW{1'b0}}, mul_a} * {{CW{1'b0}}, mul_b};

    assign sum_all = {2'b00, count_reg[0]} + {2'b00, count_reg[1]} + {2'b00, count_reg[2]};
    assign used    = {2'b00, share_reg[0]} + {2'b00, share_reg[1]} + {2'b00, share_reg[2]};
    assign target  = (share_reg[pressed_reg] != '0) ? pressed_reg
                                                    : rgbtsm_pkg::next_ch(pressed_reg);
    assign up_val  = {1'b0, count_reg[key.ch]} + {{(CW-rgbtsm_pkg::STEP_W+1){1'b0}},
                                                  cfg.step_size};

    always_comb begin
        count_next   = count_reg;
        len_next     = len_reg;
        share_next   = share_reg;
        slot_next    = slot_reg;
        ticks_next   = ticks_reg;
        active_next  = active_reg;
        state_next   = state_reg;
        idx_next     = idx_reg;
        pressed_next = pressed_reg;
        sum_next     = sum_reg;
        load_out     = 1'b0;
        div_req      = '{start: 1'b0, dividend: mul_p, divisor: sum_reg};

        case (state_reg)
            rgbtsm_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == rgbtsm_pkg::KIND_TICK) begin
                        load_out = 1'b1;
                        if (active_reg) begin
                            if (ticks_reg <= LW'(1)) begin
                                slot_next  = rgbtsm_pkg::next_ch(slot_reg);
                                ticks_next = len_reg[rgbtsm_pkg::next_ch(slot_reg)];
                            end else begin
                                ticks_next = ticks_reg - LW'(1);
                            end
                        end
                    end else if (key.hit) begin
                        // Update the pressed count, saturate up, floor at zero down
                        if (key.up) begin
                            count_next[key.ch] = (up_val > {1'b0, rgbtsm_pkg::COUNT_MAX}) ?
                                                 rgbtsm_pkg::COUNT_MAX : up_val[CW-1:0];
                        end else begin
                            count_next[key.ch] =
                                (count_reg[key.ch] > CW'(cfg.step_size)) ?
                                count_reg[key.ch] - CW'(cfg.step_size) : '0;
                        end
                        pressed_next = key.ch;
                        state_next   = rgbtsm_pkg::ST_SUM;
                    end else begin
                        // Unknown code: report state unchanged
                        load_out = 1'b1;
                    end
                end
            end
            rgbtsm_pkg::ST_SUM: begin
                idx_next = rgbtsm_pkg::CH_RED;
                if (sum_all > {3'b000, cfg.full_scale} || sum_all == '0) begin
                    // Overflow or nothing lit: clear counts, all shares zero
                    if (sum_all != '0) begin
                        count_next = '{default: '0};
                    end
                    share_next = '{default: '0};
                    state_next = rgbtsm_pkg::ST_LEN;
                end else begin
                    sum_next   = sum_all[SW-1:0];
                    state_next = rgbtsm_pkg::ST_MUL;
                end
            end
            rgbtsm_pkg::ST_MUL: begin
                div_req.start = 1'b1;
                state_next    = rgbtsm_pkg::ST_DWAIT;
            end
            rgbtsm_pkg::ST_DWAIT: begin
                if (div_rsp.done) begin
                    share_next[idx_reg] = div_rsp.quotient;
                    if (idx_reg == rgbtsm_pkg::CH_BLUE) begin
                        state_next = rgbtsm_pkg::ST_FIX;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = rgbtsm_pkg::ST_MUL;
                    end
                end
            end
            rgbtsm_pkg::ST_FIX: begin
                // Hand the leftover units to the pressed channel or its neighbour
                if (used < {2'b00, cfg.full_scale}) begin
                    share_next[target] = share_reg[target] + (cfg.full_scale - used[SW-1:0]);
                end
                idx_next   = rgbtsm_pkg::CH_RED;
                state_next = rgbtsm_pkg::ST_LEN;
            end
            rgbtsm_pkg::ST_LEN: begin
                len_next[idx_reg] = mul_p[LW-1:0] + LW'(1);
                if (idx_reg == rgbtsm_pkg::CH_BLUE) begin
                    state_next = rgbtsm_pkg::ST_DONE;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            rgbtsm_pkg::ST_DONE: begin
                active_next = (count_reg[0] | count_reg[1] | count_reg[2]) != '0;
                slot_next   = rgbtsm_pkg::CH_RED;
                ticks_next  = active_next ? len_reg[0] : '0;
                load_out    = 1'b1;
                state_next  = rgbtsm_pkg::ST_IDLE;
            end
            default: begin
                state_next = rgbtsm_pkg::ST_IDLE;
            end
        endcase
    end

    // Result fields from the state after this event
    always_comb begin
        led = 3'b000;
        if (active_next && count_next[slot_next] != '0) begin
            led = 3'b001 << slot_next;
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = {active_next, slot_next, led};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rgbtsm_pkg::ST_IDLE;
            count_reg   <= '{default: '0};
            len_reg     <= '{default: LW'(1)};
            slot_reg    <= rgbtsm_pkg::CH_RED;
            ticks_reg   <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            idx_reg     <= rgbtsm_pkg::CH_RED;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            len_reg     <= len_next;
            slot_reg    <= slot_next;
            ticks_reg   <= ticks_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
        share_reg   <= share_next;
        pressed_reg <= pressed_next;
        sum_reg     <= sum_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    // Checks
    `RGBTSM_ASSERT_NOW(a_led_onehot, m_tvalid, $onehot0(m_tdata[2:0]))
    `RGBTSM_ASSERT_NOW(a_led_needs_run, m_tvalid && !m_tdata[5], m_tdata[2:0] == 3'b000)
    `RGBTSM_ASSERT_NOW(a_slot_range, m_tvalid, m_tdata[4:3] != 2'd3)
    `RGBTSM_ASSERT_NEXT(a_key_blocks, key_start, !s_tready && !m_tvalid)

endmodule
